FILE: rtl/gn2d_pkg.sv
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types, widths and arithmetic helpers of the 2D gradient noise
// evaluator.
// ----------------------------------------------------------------------------
package gn2d_pkg;

   // fixed field widths
   localparam int GRID_CELLS_DEF = 16;
   localparam int FRAC_BITS      = 8;
   localparam int PT_W           = 12;
   localparam int COORD_W        = 5;
   localparam int GRAD_W         = 16;
   localparam int NOISE_W        = 16;

   // request tdata layout, lowest field first
   localparam int REQ_COL_LO  = 0;
   localparam int REQ_ROW_LO  = REQ_COL_LO + COORD_W;
   localparam int REQ_GX_LO   = REQ_ROW_LO + COORD_W;
   localparam int REQ_GY_LO   = REQ_GX_LO + GRAD_W;
   localparam int REQ_PX_LO   = REQ_GY_LO + GRAD_W;
   localparam int REQ_PY_LO   = REQ_PX_LO + PT_W;
   localparam int REQ_USED_W  = REQ_PY_LO + PT_W;
   localparam int REQ_DATA_W  = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((NOISE_W + 7) / 8) * 8;

   // datapath widths
   localparam int IX_W     = PT_W - FRAC_BITS;
   localparam int DX_W     = FRAC_BITS + 2;
   localparam int PROD_W   = GRAD_W + DX_W;
   localparam int DOT_W    = PROD_W + 1;
   localparam int D_W      = DOT_W - FRAC_BITS;
   localparam int FF_W     = 2 * FRAC_BITS;
   localparam int WN_W     = 3 * FRAC_BITS + 2;
   localparam int W_W      = 17;
   localparam int W_FRAC   = 16;
   localparam int BL_W     = D_W + 1 + W_W + 1;
   localparam int WSH_R    = (3 * FRAC_BITS >= W_FRAC) ? 3 * FRAC_BITS - W_FRAC : 0;
   localparam int WSH_L    = (3 * FRAC_BITS >= W_FRAC) ? 0 : W_FRAC - 3 * FRAC_BITS;

   // accept edge to result: read stage plus four compute stages
   localparam int PIPE_STAGES = 5;

   localparam logic signed [D_W-1:0] SAT_HI = D_W'(2 ** (NOISE_W - 1) - 1);
   localparam logic signed [D_W-1:0] SAT_LO = -SAT_HI - D_W'(1);

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gy;
      logic signed [GRAD_W-1:0] gx;
   } grad_type;

   typedef struct packed {
      logic               en;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      grad_type           grad;
   } lat_wr_type;

   // f*f*(3*2^F - 2f) brought to Q0.16
   function automatic logic [W_W-1:0] weight16(input logic [WN_W-1:0] num);
      logic [WN_W+W_FRAC-1:0] t;
      t = (WN_W + W_FRAC)'(num);
      t = (t >> WSH_R) << WSH_L;
      return W_W'(t);
   endfunction

   // a + floor((b - a) * s / 2^16)
   function automatic logic signed [D_W-1:0] blend(input logic signed [D_W-1:0] a,
                                                   input logic signed [D_W-1:0] b,
                                                   input logic [W_W-1:0] s);
      logic signed [D_W:0]    diff;
      logic signed [BL_W-1:0] prod;
      logic signed [BL_W-1:0] sh;
      diff = (D_W + 1)'(b) - (D_W + 1)'(a);
      prod = BL_W'(diff) * BL_W'($signed({1'b0, s}));
      sh   = prod >>> W_FRAC;
      return a + D_W'(sh);
   endfunction

endpackage

FILE: rtl/gradient_noise_2d_eval.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_eval
// 2D gradient noise evaluator over a stored lattice of gradients.
// ----------------------------------------------------------------------------
// Takes one item per cycle whenever req_tready is high, write or evaluate,
// with no gaps needed between them. A write stores one lattice gradient and
// returns nothing; writes outside the lattice are dropped. An evaluate returns
// one Q2.14 noise value through the lattice read and four arithmetic stages.
// The lattice sits in four RAM banks split by row and column parity, so all
// four corners of a cell are read in the same cycle, and every stage holds
// independently, so input transfers continue while a result waits for
// rsp_tready as long as some stage is empty. The lattice has no reset:
// evaluate only cells whose corners were written. A write is visible to any
// evaluate that follows it.
// ----------------------------------------------------------------------------
module gradient_noise_2d_eval #(
   parameter int GRID_CELLS = gn2d_pkg::GRID_CELLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // lattice_col, lattice_row, grad_x, grad_y, point_x, point_y, zero pad
   input  logic [gn2d_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // noise_value
   output logic [gn2d_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CELL_W = $clog2(GRID_CELLS);
   localparam int F      = gn2d_pkg::FRAC_BITS;
   localparam int PT_W   = gn2d_pkg::PT_W;

   logic                               is_eval;
   logic [PT_W-1:0]                    px, py;
   logic [gn2d_pkg::IX_W-1:0]          ix, iy;
   logic [CELL_W-1:0]                  cx, cy;
   gn2d_pkg::lat_wr_type               wr;
   gn2d_pkg::grad_type                 corner [4];
   logic signed [gn2d_pkg::NOISE_W-1:0] noise;
   logic                               dp_ready;

   always_comb begin
      is_eval = (gn2d_pkg::opcode_type'(req_tuser) == gn2d_pkg::OP_EVAL);
      px      = req_tdata[gn2d_pkg::REQ_PX_LO +: PT_W];
      py      = req_tdata[gn2d_pkg::REQ_PY_LO +: PT_W];
      ix      = px[PT_W-1:F];
      iy      = py[PT_W-1:F];
      // clamp the cell to the last one; the fraction is kept
      cx      = (32'(ix) > GRID_CELLS - 1) ? CELL_W'(GRID_CELLS - 1) : CELL_W'(ix);
      cy      = (32'(iy) > GRID_CELLS - 1) ? CELL_W'(GRID_CELLS - 1) : CELL_W'(iy);

      wr.en      = req_tvalid && dp_ready && !is_eval;
      wr.col     = req_tdata[gn2d_pkg::REQ_COL_LO +: gn2d_pkg::COORD_W];
      wr.row     = req_tdata[gn2d_pkg::REQ_ROW_LO +: gn2d_pkg::COORD_W];
      wr.grad.gx = req_tdata[gn2d_pkg::REQ_GX_LO +: gn2d_pkg::GRAD_W];
      wr.grad.gy = req_tdata[gn2d_pkg::REQ_GY_LO +: gn2d_pkg::GRAD_W];
   end

   gn2d_lattice #(
      .GRID_CELLS (GRID_CELLS)
   ) u_lattice (
      .clock  (clock),
      .wr     (wr),
      .rd_en  (dp_ready),
      .rd_cx  (cx),
      .rd_cy  (cy),
      .corner (corner)
   );

   gn2d_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && is_eval),
      .in_ready  (dp_ready),
      .in_fx     (px[F-1:0]),
      .in_fy     (py[F-1:0]),
      .corner    (corner),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (noise)
   );

   assign req_tready = dp_ready;
   assign rsp_tdata  = gn2d_pkg::RSP_DATA_W'($unsigned(noise));

endmodule

FILE: rtl/gn2d_ram.sv
// ----------------------------------------------------------------------------
// gn2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gn2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gn2d_lattice.sv
// ----------------------------------------------------------------------------
// gn2d_lattice
// Gradient lattice split into four banks by row and column parity, so the
// four corners of any cell are read in the same cycle.
// ----------------------------------------------------------------------------
module gn2d_lattice #(
   parameter int GRID_CELLS = gn2d_pkg::GRID_CELLS_DEF
) (
   input  logic                          clock,
   input  gn2d_pkg::lat_wr_type          wr,
   input  logic                          rd_en,
   input  logic [$clog2(GRID_CELLS)-1:0] rd_cx,
   input  logic [$clog2(GRID_CELLS)-1:0] rd_cy,
   output gn2d_pkg::grad_type            corner [4]
);

   localparam int CELL_W     = $clog2(GRID_CELLS);
   localparam int LAT_W      = $clog2(GRID_CELLS + 1);
   localparam int HALF       = GRID_CELLS / 2 + 1;
   localparam int BANK_DEPTH = HALF * HALF;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int GRAD_BITS  = $bits(gn2d_pkg::grad_type);

   logic                 wr_ok;
   logic [1:0]           wr_bank;
   logic [BANK_AW-1:0]   wr_addr;
   logic [LAT_W-1:0]     cx0, cx1, cy0, cy1;
   logic [1:0]           par_ff, par_in;
   logic [GRAD_BITS-1:0] bank_q [4];

   always_comb begin
      wr_ok   = wr.en && (32'(wr.col) <= GRID_CELLS) && (32'(wr.row) <= GRID_CELLS);
      wr_bank = {wr.row[0], wr.col[0]};
      wr_addr = BANK_AW'(32'(wr.row[gn2d_pkg::COORD_W-1:1]) * HALF
                         + 32'(wr.col[gn2d_pkg::COORD_W-1:1]));
      cx0     = LAT_W'(rd_cx);
      cx1     = LAT_W'(rd_cx) + LAT_W'(1);
      cy0     = LAT_W'(rd_cy);
      cy1     = LAT_W'(rd_cy) + LAT_W'(1);
      par_in  = rd_en ? {rd_cy[0], rd_cx[0]} : par_ff;
   end

   always_ff @(posedge clock) begin
      par_ff <= par_in;
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [LAT_W-1:0]   r_sel, c_sel;
      logic [BANK_AW-1:0] rd_addr;

      // pick whichever of the two candidate rows / columns has this parity
      always_comb begin
         r_sel   = (cy0[0] == 1'(b >> 1)) ? cy0 : cy1;
         c_sel   = (cx0[0] == 1'(b & 1))  ? cx0 : cx1;
         rd_addr = BANK_AW'(32'(r_sel[LAT_W-1:1]) * HALF + 32'(c_sel[LAT_W-1:1]));
      end

      gn2d_ram #(
         .WIDTH (GRAD_BITS),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_ok && (wr_bank == 2'(b))),
         .wr_addr (wr_addr),
         .wr_data (wr.grad),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (bank_q[b])
      );
   end

   // corner k sits at column offset k[0], row offset k[1]
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         corner[k] = gn2d_pkg::grad_type'(bank_q[par_ff ^ 2'(k)]);
      end
   end

   logic unused_cell;
   assign unused_cell = ^{CELL_W{1'b0}};

endmodule

FILE: rtl/gn2d_datapath.sv
// ----------------------------------------------------------------------------
// gn2d_datapath
// Pipeline from lattice read data to noise value: corner products, dot
// products and weights, x blend, y blend with saturation.
// ----------------------------------------------------------------------------
module gn2d_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [gn2d_pkg::FRAC_BITS-1:0]         in_fx,
   input  logic [gn2d_pkg::FRAC_BITS-1:0]         in_fy,
   input  gn2d_pkg::grad_type                     corner [4],
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [gn2d_pkg::NOISE_W-1:0]    rsp_value
);

   localparam int F    = gn2d_pkg::FRAC_BITS;
   localparam int DX_W = gn2d_pkg::DX_W;
   localparam int PW   = gn2d_pkg::PROD_W;
   localparam int DTW  = gn2d_pkg::DOT_W;
   localparam int DW   = gn2d_pkg::D_W;
   localparam int FFW  = gn2d_pkg::FF_W;
   localparam int WNW  = gn2d_pkg::WN_W;
   localparam int WW   = gn2d_pkg::W_W;
   localparam int NW   = gn2d_pkg::NOISE_W;

   localparam logic [DX_W-1:0] ONE_DX   = DX_W'(2 ** F);
   localparam logic [DX_W-1:0] THREE_DX = DX_W'(3 * (2 ** F));

   // stage valids and loads; a stage loads when empty or when it drains
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic va_in, vb_in, vc_in, vd_in, ve_in;
   logic ld_a, ld_b, ld_c, ld_d, ld_e;

   // stage A: lattice read in flight
   logic [F-1:0] fxa_ff, fxa_in, fya_ff, fya_in;
   // stage B: products
   logic signed [PW-1:0] pxb_ff [4], pxb_in [4], pyb_ff [4], pyb_in [4];
   logic [FFW-1:0]       ffxb_ff, ffxb_in, ffyb_ff, ffyb_in;
   logic [F-1:0]         fxb_ff, fxb_in, fyb_ff, fyb_in;
   // stage C: dot products and weights
   logic signed [DW-1:0] dc_ff [4], dc_in [4];
   logic [WW-1:0]        sxc_ff, sxc_in, syc_ff, syc_in;
   // stage D: x blends
   logic signed [DW-1:0] l1d_ff, l1d_in, l2d_ff, l2d_in;
   logic [WW-1:0]        syd_ff, syd_in;
   // stage E: result
   logic signed [NW-1:0] re_ff, re_in;

   logic signed [DX_W-1:0] dxv [2], dyv [2];
   logic signed [DTW-1:0]  dot;
   logic [DX_W-1:0]        tx, ty;
   logic signed [DW-1:0]   r;

   always_comb begin
      ld_e     = !ve_ff || rsp_ready;
      ld_d     = !vd_ff || ld_e;
      ld_c     = !vc_ff || ld_d;
      ld_b     = !vb_ff || ld_c;
      ld_a     = !va_ff || ld_b;
      in_ready = ld_a;

      va_in = ld_a ? in_valid : va_ff;
      vb_in = ld_b ? va_ff : vb_ff;
      vc_in = ld_c ? vb_ff : vc_ff;
      vd_in = ld_d ? vc_ff : vd_ff;
      ve_in = ld_e ? vd_ff : ve_ff;

      // stage A
      fxa_in = ld_a ? in_fx : fxa_ff;
      fya_in = ld_a ? in_fy : fya_ff;

      // stage B: offsets from the near and far corner, then products
      dxv[0] = $signed({2'b00, fxa_ff});
      dxv[1] = $signed({2'b00, fxa_ff} - ONE_DX);
      dyv[0] = $signed({2'b00, fya_ff});
      dyv[1] = $signed({2'b00, fya_ff} - ONE_DX);
      for (int k = 0; k < 4; k++) begin
         pxb_in[k] = ld_b ? PW'(corner[k].gx) * PW'(dxv[k & 1]) : pxb_ff[k];
         pyb_in[k] = ld_b ? PW'(corner[k].gy) * PW'(dyv[k >> 1]) : pyb_ff[k];
      end
      ffxb_in = ld_b ? FFW'(fxa_ff) * FFW'(fxa_ff) : ffxb_ff;
      ffyb_in = ld_b ? FFW'(fya_ff) * FFW'(fya_ff) : ffyb_ff;
      fxb_in  = ld_b ? fxa_ff : fxb_ff;
      fyb_in  = ld_b ? fya_ff : fyb_ff;

      // stage C: dot products to Q.14 (floor), smoothstep weights
      for (int k = 0; k < 4; k++) begin
         dot      = DTW'(pxb_ff[k]) + DTW'(pyb_ff[k]);
         dc_in[k] = ld_c ? DW'(dot >>> F) : dc_ff[k];
      end
      tx     = THREE_DX - DX_W'({fxb_ff, 1'b0});
      ty     = THREE_DX - DX_W'({fyb_ff, 1'b0});
      sxc_in = ld_c ? gn2d_pkg::weight16(WNW'(ffxb_ff) * WNW'(tx)) : sxc_ff;
      syc_in = ld_c ? gn2d_pkg::weight16(WNW'(ffyb_ff) * WNW'(ty)) : syc_ff;

      // stage D: blend in x
      l1d_in = ld_d ? gn2d_pkg::blend(dc_ff[0], dc_ff[1], sxc_ff) : l1d_ff;
      l2d_in = ld_d ? gn2d_pkg::blend(dc_ff[2], dc_ff[3], sxc_ff) : l2d_ff;
      syd_in = ld_d ? syc_ff : syd_ff;

      // stage E: blend in y, saturate
      r = gn2d_pkg::blend(l1d_ff, l2d_ff, syd_ff);
      if (!ld_e) begin
         re_in = re_ff;
      end else if (r > gn2d_pkg::SAT_HI) begin
         re_in = NW'(gn2d_pkg::SAT_HI);
      end else if (r < gn2d_pkg::SAT_LO) begin
         re_in = NW'(gn2d_pkg::SAT_LO);
      end else begin
         re_in = NW'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
         vd_ff <= vd_in;
         ve_ff <= ve_in;
      end
   end

   always_ff @(posedge clock) begin
      fxa_ff  <= fxa_in;
      fya_ff  <= fya_in;
      pxb_ff  <= pxb_in;
      pyb_ff  <= pyb_in;
      ffxb_ff <= ffxb_in;
      ffyb_ff <= ffyb_in;
      fxb_ff  <= fxb_in;
      fyb_ff  <= fyb_in;
      dc_ff   <= dc_in;
      sxc_ff  <= sxc_in;
      syc_ff  <= syc_in;
      l1d_ff  <= l1d_in;
      l2d_ff  <= l2d_in;
      syd_ff  <= syd_in;
      re_ff   <= re_in;
   end

   assign rsp_valid = ve_ff;
   assign rsp_value = re_ff;

endmodule

FILE: rtl/gn2d_checker.sv
// ----------------------------------------------------------------------------
// gn2d_checker
// Port-level checks of the noise evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module gn2d_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gn2d_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [0:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gn2d_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PEND_W = $clog2(gn2d_pkg::PIPE_STAGES + 1) + 1;

   logic              eval_xfer, rsp_xfer;
   logic [PEND_W-1:0] pend_ff, pend_in;

   always_comb begin
      eval_xfer = req_tvalid && req_tready
                  && (gn2d_pkg::opcode_type'(req_tuser) == gn2d_pkg::OP_EVAL);
      rsp_xfer  = rsp_tvalid && rsp_tready;
      pend_in   = pend_ff + PEND_W'(eval_xfer) - PEND_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a result only ever answers an evaluate transfer
   a_rsp_has_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != '0)
      else $error("result without an outstanding evaluate");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_W'(gn2d_pkg::PIPE_STAGES))
      else $error("more evaluates in flight than pipeline stages");

   // with no result waiting every stage can load
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   logic unused_data;
   assign unused_data = ^req_tdata;

endmodule

bind gradient_noise_2d_eval gn2d_checker u_gn2d_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D gradient noise evaluator.
// ----------------------------------------------------------------------------
// A queue of gradient writes and point evaluations drives the request stream.
// Every accepted write updates a local copy of the lattice, and each
// evaluate is predicted in exact integer math. The expected noise values
// wait in order until they are compared against the response stream. Both
// sides idle at random in phases: sender light and receiver heavy, then the
// reverse, then no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
   import gn2d_pkg::*;

   localparam int LAT_SIDE    = GRID_CELLS_DEF + 1;
   localparam int LAT_SIZE    = LAT_SIDE * LAT_SIDE;
   localparam int GRAD_MAX    = 16384;
   localparam int ITEM_TARGET = 1400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      opcode_type               op;
      logic [COORD_W-1:0]       col;
      logic [COORD_W-1:0]       row;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic [PT_W-1:0]          px;
      logic [PT_W-1:0]          py;
   } req_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   req_item_type             pending_items[$];
   logic signed [NOISE_W-1:0] expected_noise[$];
   grad_type                 lattice_grads[LAT_SIZE];
   bit                       lattice_loaded[LAT_SIZE];
   bit                       stim_ready = 1'b0;
   bit                       req_taken = 1'b0;
   int                       total_items;
   int                       live_items = 0;
   int                       accepted_count = 0;
   int                       err_count = 0;
   int                       cycle_count = 0;

   gradient_noise_2d_eval dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic longint corner_dot(input int col, input int row,
                                         input longint dx, input longint dy);
      grad_type g;
      g = lattice_grads[row * LAT_SIDE + col];
      return (longint'($signed(g.gx)) * dx + longint'($signed(g.gy)) * dy) >>> FRAC_BITS;
   endfunction

   function automatic longint smooth_weight(input longint f);
      longint num;
      num = f * f * (3 * (longint'(1) << FRAC_BITS) - 2 * f);
      if (3 * FRAC_BITS >= 16)
         return num >>> (3 * FRAC_BITS - 16);
      return num << (16 - 3 * FRAC_BITS);
   endfunction

   function automatic longint lerp_q16(input longint a, input longint b, input longint s);
      return a + (((b - a) * s) >>> 16);
   endfunction

   function automatic logic signed [NOISE_W-1:0] eval_noise(input logic [PT_W-1:0] px,
                                                            input logic [PT_W-1:0] py);
      int     cx, cy;
      longint fx, fy, one, sx, sy, l1, l2, r;
      one = longint'(1) << FRAC_BITS;
      fx  = longint'(px) & (one - 1);
      fy  = longint'(py) & (one - 1);
      cx  = int'(px >> FRAC_BITS);
      cy  = int'(py >> FRAC_BITS);
      // clamp the cell index to the last cell, keep the fraction
      if (cx > GRID_CELLS_DEF - 1) cx = GRID_CELLS_DEF - 1;
      if (cy > GRID_CELLS_DEF - 1) cy = GRID_CELLS_DEF - 1;
      sx = smooth_weight(fx);
      sy = smooth_weight(fy);
      l1 = lerp_q16(corner_dot(cx, cy, fx, fy), corner_dot(cx + 1, cy, fx - one, fy), sx);
      l2 = lerp_q16(corner_dot(cx, cy + 1, fx, fy - one),
                    corner_dot(cx + 1, cy + 1, fx - one, fy - one), sx);
      r  = lerp_q16(l1, l2, sy);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return NOISE_W'(r);
   endfunction

   task automatic apply_item(input req_item_type it);
      grad_type g;
      if (it.op == OP_WRITE) begin
         // drop writes that fall outside the lattice
         if (it.col <= GRID_CELLS_DEF && it.row <= GRID_CELLS_DEF) begin
            g.gx = it.gx;
            g.gy = it.gy;
            lattice_grads[it.row * LAT_SIDE + it.col] = g;
         end
      end else begin
         expected_noise = {expected_noise, eval_noise(it.px, it.py)};
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [GRAD_W-1:0] rand_grad();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return GRAD_W'(GRAD_MAX);
      if (pick == 1) return GRAD_W'(-GRAD_MAX);
      return GRAD_W'(int'($urandom_range(2 * GRAD_MAX)) - GRAD_MAX);
   endfunction

   // unused fields carry random bits so every bit toggles
   function automatic req_item_type rand_item(input opcode_type op);
      req_item_type it;
      it.op  = op;
      it.col = COORD_W'($urandom);
      it.row = COORD_W'($urandom);
      it.gx  = GRAD_W'($urandom);
      it.gy  = GRAD_W'($urandom);
      it.px  = PT_W'($urandom);
      it.py  = PT_W'($urandom);
      return it;
   endfunction

   task automatic queue_write(input int col, input int row,
                              input logic signed [GRAD_W-1:0] gx,
                              input logic signed [GRAD_W-1:0] gy);
      req_item_type it;
      it     = rand_item(OP_WRITE);
      it.col = COORD_W'(col);
      it.row = COORD_W'(row);
      it.gx  = gx;
      it.gy  = gy;
      pending_items = {pending_items, it};
      if (col <= GRID_CELLS_DEF && row <= GRID_CELLS_DEF) begin
         lattice_loaded[row * LAT_SIDE + col] = 1'b1;
         live_items++;
      end
   endtask

   // load any missing corner first, so no unwritten entry is ever read
   task automatic queue_eval(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py);
      req_item_type it;
      int           cx, cy;
      cx = int'(px >> FRAC_BITS);
      cy = int'(py >> FRAC_BITS);
      if (cx > GRID_CELLS_DEF - 1) cx = GRID_CELLS_DEF - 1;
      if (cy > GRID_CELLS_DEF - 1) cy = GRID_CELLS_DEF - 1;
      for (int k = 0; k < 4; k++) begin
         if (!lattice_loaded[(cy + k / 2) * LAT_SIDE + cx + k % 2])
            queue_write(cx + k % 2, cy + k / 2, rand_grad(), rand_grad());
      end
      it    = rand_item(OP_EVAL);
      it.px = px;
      it.py = py;
      pending_items = {pending_items, it};
      live_items++;
   endtask

   task automatic build_stimulus();
      int pick;
      int frac_x, frac_y;
      // extreme gradients around the first cell
      queue_write(0, 0, GRAD_W'(GRAD_MAX), GRAD_W'(GRAD_MAX));
      queue_write(1, 0, GRAD_W'(-GRAD_MAX), GRAD_W'(-GRAD_MAX));
      queue_write(0, 1, GRAD_W'(-GRAD_MAX), GRAD_W'(GRAD_MAX));
      queue_write(1, 1, GRAD_W'(GRAD_MAX), GRAD_W'(-GRAD_MAX));
      queue_eval(12'h000, 12'h000);
      queue_eval(12'h0FF, 12'h0FF);
      queue_eval(12'h080, 12'h080);
      queue_eval(12'h0FF, 12'h000);
      // last cell of the lattice, far corner on the border
      queue_write(15, 15, GRAD_W'(-GRAD_MAX), GRAD_W'(GRAD_MAX));
      queue_write(16, 15, GRAD_W'(GRAD_MAX), GRAD_W'(GRAD_MAX));
      queue_write(15, 16, GRAD_W'(-GRAD_MAX), GRAD_W'(-GRAD_MAX));
      queue_write(16, 16, GRAD_W'(GRAD_MAX), GRAD_W'(-GRAD_MAX));
      queue_eval(12'hFFF, 12'hFFF);
      queue_eval(12'hF00, 12'hF00);
      // outside the lattice: must not alias onto the first cell
      queue_write(17, 0, GRAD_W'(0), GRAD_W'(0));
      queue_write(31, 31, GRAD_W'(0), GRAD_W'(0));
      queue_eval(12'h0C0, 12'h040);

      while (live_items < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            queue_eval(PT_W'($urandom), PT_W'($urandom));
         end else if (pick < 68) begin
            frac_x = $urandom_range(1) ? 8'hFF : 8'h00;
            frac_y = $urandom_range(1) ? 8'hFF : 8'h00;
            queue_eval({4'($urandom), 8'(frac_x)}, {4'($urandom), 8'(frac_y)});
         end else if (pick < 90) begin
            queue_write($urandom_range(GRID_CELLS_DEF), $urandom_range(GRID_CELLS_DEF),
                        rand_grad(), rand_grad());
         end else if (pick < 95) begin
            queue_write($urandom_range(31, GRID_CELLS_DEF + 1), $urandom_range(31),
                        rand_grad(), rand_grad());
         end else begin
            queue_write($urandom_range(31), $urandom_range(31, GRID_CELLS_DEF + 1),
                        rand_grad(), rand_grad());
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : drive_req
      req_item_type          it;
      logic [REQ_DATA_W-1:0] word;
      int                    phase;
      int                    send_idle, recv_idle;
      if (!reset && stim_ready) begin
         phase     = accepted_count * 3 / total_items;
         send_idle = (phase == 0) ? 29 : (phase == 1) ? 79 : 0;
         recv_idle = (phase == 0) ? 79 : (phase == 1) ? 29 : 0;
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         // hold the current item until its transfer
         if (!(req_tvalid && !req_taken)) begin
            req_taken = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
               it   = pending_items[0];
               word = '0;
               word[REQ_COL_LO +: COORD_W] = it.col;
               word[REQ_ROW_LO +: COORD_W] = it.row;
               word[REQ_GX_LO  +: GRAD_W]  = it.gx;
               word[REQ_GY_LO  +: GRAD_W]  = it.gy;
               word[REQ_PX_LO  +: PT_W]    = it.px;
               word[REQ_PY_LO  +: PT_W]    = it.py;
               req_tvalid <= 1'b1;
               req_tdata  <= word;
               req_tuser  <= it.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : watch_streams
      logic signed [NOISE_W-1:0] want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_item(pending_items.pop_front());
            req_taken = 1'b1;
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_noise.size() == 0) begin
               report_mismatch($sformatf("unexpected result noise_value=%0h",
                                         rsp_tdata[NOISE_W-1:0]));
            end else begin
               want = expected_noise.pop_front();
               if (rsp_tdata[NOISE_W-1:0] !== want)
                  report_mismatch($sformatf("noise_value got %0h want %0h",
                                            rsp_tdata[NOISE_W-1:0], want));
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      foreach (lattice_grads[i]) lattice_grads[i] = '0;
      build_stimulus();
      total_items = pending_items.size();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset      <= 1'b0;
      stim_ready = 1'b1;
      while (pending_items.size() != 0 || expected_noise.size() != 0)
         @(posedge clock);
      // catch any stray result after the last expected one
      repeat (4 * PIPE_STAGES) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: gradient_noise_2d_eval.f
rtl/gn2d_pkg.sv
rtl/gn2d_ram.sv
rtl/gn2d_lattice.sv
rtl/gn2d_datapath.sv
rtl/gradient_noise_2d_eval.sv
rtl/gn2d_checker.sv
tb/tb_top.sv
